>>> rtl/image_crc16_checker_unit_defines.svh
// Assertion helpers for the checker file.
`ifndef IMAGE_CRC16_CHECKER_UNIT_DEFINES_SVH
`define IMAGE_CRC16_CHECKER_UNIT_DEFINES_SVH

// Check a property that only has meaning once reset has been released.
`define ICRC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check a property at every edge, including the edges inside reset.
`define ICRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/icrc_pkg.sv
package icrc_pkg;

    localparam int POS_BITS     = 18;
    localparam int OFFSET_W     = 18;
    localparam int CRC_W        = 16;
    localparam int BYTE_W       = 8;
    localparam int FIELD_LEN    = 4;

    localparam logic [CRC_W-1:0] CRC_POLY      = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_ZERO      = 16'h0000;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES  = 16'hFFFF;
    localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;

    // Position inside the CRC field, relative to its first byte
    localparam logic [POS_BITS-1:0] REL_CRC_LOW  = 18'd0;
    localparam logic [POS_BITS-1:0] REL_CRC_HIGH = 18'd1;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CRC_FIELD_OFFSET = 1'b0;

    typedef struct packed {
        logic             image_ok;
        logic [CRC_W-1:0] stored_crc;
        logic [CRC_W-1:0] computed_crc;
    } icrc_result_t;

    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(icrc_result_t);

    // Shift one byte MSB-first into a non-reflected CRC-16 register.
    function automatic logic [CRC_W-1:0] crc_shift_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] byte_in
    );
        logic [CRC_W-1:0]  c;
        logic [BYTE_W-1:0] d;
        logic              top;
        c = crc_in;
        d = byte_in;
        for (int i = 0; i < BYTE_W; i++)
        begin
            top = c[CRC_W-1];
            c   = {c[CRC_W-2:0], d[BYTE_W-1]};
            if (top)
            begin
                c = c ^ CRC_POLY;
            end
            d = {d[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/icrc_core.sv
module icrc_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [icrc_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last,
    input  logic [icrc_pkg::OFFSET_W-1:0] crc_field_offset,
    output icrc_pkg::icrc_result_t        result
);
    import icrc_pkg::*;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [CRC_W-1:0]    crc_reg, crc_next;
    logic [CRC_W-1:0]    cap_reg, cap_next;

    logic [POS_BITS-1:0] rel;
    logic                in_field;
    logic [CRC_W-1:0]    crc_upd;
    logic [CRC_W-1:0]    cap_upd;
    logic [CRC_W-1:0]    crc_final;

    // Distance from the start of the CRC field, wrapping with the counter
    assign rel      = pos_reg - POS_BITS'(crc_field_offset);
    assign in_field = (rel < POS_BITS'(FIELD_LEN));

    always_comb
    begin
        crc_upd = in_field ? crc_reg : crc_shift_byte(crc_reg, data_byte);
        cap_upd = cap_reg;
        if (rel == REL_CRC_LOW)
        begin
            cap_upd = {cap_reg[CRC_W-1:BYTE_W], data_byte};
        end
        else if (rel == REL_CRC_HIGH)
        begin
            cap_upd = {data_byte, cap_reg[BYTE_W-1:0]};
        end
        // Augment: flush two zero bytes through the register
        crc_final = crc_shift_byte(crc_shift_byte(crc_upd, BYTE_ZERO), BYTE_ZERO);

        result.computed_crc = crc_final;
        result.stored_crc   = cap_upd;
        result.image_ok     = (crc_final == cap_upd) && (cap_upd != CRC_ALL_ONES)
                              && (cap_upd != CRC_ZERO);
    end

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        cap_next = cap_reg;
        if (fire)
        begin
            if (last)
            begin
                pos_next = '0;
                crc_next = CRC_ZERO;
                cap_next = CRC_ZERO;
            end
            else
            begin
                pos_next = pos_reg + POS_BITS'(1);
                crc_next = crc_upd;
                cap_next = cap_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= CRC_ZERO;
            cap_reg <= CRC_ZERO;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            cap_reg <= cap_next;
        end
    end

endmodule

>>> rtl/image_crc16_checker_unit.sv
// Firmware image CRC-16 checker.
// Input stream (s_*): one image byte per transaction in s_tdata[7:0], s_tlast
//   high on the final byte of an image.
// Output stream (m_*): one transaction per image, issued for the byte carrying
//   s_tlast; it holds the augmented CRC-16/0x1021 over all bytes except the
//   four-byte CRC field, the little-endian CRC read from that field, and the
//   image_ok flag (match, and stored value neither all ones nor all zeros).
// APB port: register 0 at address 0 is crc_field_offset (18 bits), the byte
//   position of the CRC field. Write it only while no image is in flight.
// A byte in the input register is processed into the running state; for a
//   last byte the result is loaded into the output register for m_tvalid.
// Throughput: one byte per cycle unless a final byte waits for the output
//   register. The whole byte update, including the two-zero-byte flush on the
//   last byte, is one XOR network between the input and state/result registers.
// Reset: position, running CRC, captured CRC and offset clear to zero; both
//   valid flags drop.
// Receiver stall: the result stays in the output register; non-final bytes
//   keep flowing, and a final byte waits in the input register, back-pressuring
//   s_tready, until the output register frees up.
module image_crc16_checker_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [icrc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [icrc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [icrc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Byte stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [icrc_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] data_byte
    input  logic                              s_tlast,  // last
    // Result stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [icrc_pkg::OUT_TDATA_W-1:0]  m_tdata   // [15:0] computed_crc,
                                                        // [31:16] stored_crc,
                                                        // [32] image_ok, [39:33] 0
);
    import icrc_pkg::*;

    logic [OFFSET_W-1:0]  offset_reg, offset_next;
    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]    in_data_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg, out_valid_next;
    icrc_result_t         out_result_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 out_free;
    logic                 fire;
    logic                 s_accept;
    icrc_result_t         core_result;

    // ---- APB register file ----
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        offset_next = offset_reg;
        if (cfg_write && (reg_idx == REG_CRC_FIELD_OFFSET))
        begin
            offset_next = pwdata[OFFSET_W-1:0];
        end
        prdata = '0;
        if (reg_idx == REG_CRC_FIELD_OFFSET)
        begin
            prdata = APB_DATA_W'(offset_reg);
        end
    end

    // ---- Handshake ----
    // A non-final byte only touches the running state; a final byte also
    // needs room in the output register.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---- CRC datapath ----
    icrc_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .data_byte        (in_data_reg),
        .last             (in_last_reg),
        .crc_field_offset (offset_reg),
        .result           (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (fire && in_last_reg)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_result_reg};

endmodule

>>> rtl/icrc_checker.sv
`include "image_crc16_checker_unit_defines.svh"

module icrc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [icrc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import icrc_pkg::*;

    `ICRC_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `ICRC_ASSERT(a_ok_match, clk, rst_n, m_tvalid && m_tdata[2*CRC_W] |-> m_tdata[CRC_W-1:0] == m_tdata[2*CRC_W-1:CRC_W], "image_ok set on mismatching CRCs")
    `ICRC_ASSERT(a_ok_stored, clk, rst_n, m_tvalid && m_tdata[2*CRC_W] |-> m_tdata[2*CRC_W-1:CRC_W] != CRC_ALL_ONES && m_tdata[2*CRC_W-1:CRC_W] != CRC_ZERO, "image_ok set on blank stored CRC")
    `ICRC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !m_tvalid, "result valid during reset")

endmodule

bind image_crc16_checker_unit icrc_checker u_icrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
